FILE: src/kcr_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// kcr_pkg
// shared field widths, codes and controller/datapath interface structs
// ----------------------------------------------------------------------------
package kcr_pkg;

    localparam int RATING_W    = 8;
    localparam int SIM_W       = 16;
    localparam int SIM_FRAC    = 15;
    localparam int USER_W      = 8;
    localparam int ITEM_W      = 10;
    localparam int PRED_W      = 8;
    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = 11;
    localparam int CFG_USERS_W = 9;
    localparam int CFG_ITEMS_W = 11;
    localparam int CFG_NBRS_W  = 5;

    localparam logic FUNC_LOAD    = 1'b0;
    localparam logic FUNC_PREDICT = 1'b1;

    localparam logic STAT_OK    = 1'b0;
    localparam logic STAT_RANGE = 1'b1;

    localparam logic [CFG_IDX_W-1:0] CFG_USERS = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ITEMS = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_NBRS  = 2'd2;

    localparam logic [CFG_USERS_W-1:0] USERS_RST = 9'd256;
    localparam logic [CFG_ITEMS_W-1:0] ITEMS_RST = 11'd1024;
    localparam logic [CFG_NBRS_W-1:0]  NBRS_RST  = 5'd5;

    localparam logic [SIM_W-1:0] SIM_ONE = 16'h8000;

    typedef struct packed {
        logic clr_step;
        logic load_wr;
        logic pred_init;
        logic out_err;
        logic acc_start;
        logic ins_zero;
        logic mul_start;
        logic sqrt_start;
        logic div_sim_start;
        logic ins_div;
        logic next_cand;
        logic sum_step;
        logic fin_zero;
        logic div_fin_start;
        logic fin_q;
    } t_cmd;

    typedef struct packed {
        logic clr_last;
        logic pred_bad;
        logic cand_skip;
        logic acc_done;
        logic mag_zero;
        logic mul_done;
        logic sqrt_done;
        logic div_done;
        logic last_cand;
        logic sum_more;
        logic den_zero;
    } t_sts;

endpackage
`default_nettype wire

FILE: src/kcr_mul.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// kcr_mul
// shift-add multiplier, one multiplier bit per cycle
// ----------------------------------------------------------------------------
module kcr_mul #(
    parameter int W = 27
) (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_start,
    input  wire logic [W-1:0]   i_a,
    input  wire logic [W-1:0]   i_b,
    output logic      [2*W-1:0] o_p,
    output logic                o_done
);

    localparam int CW = $clog2(W + 1);

    logic           r_run;
    logic [CW-1:0]  r_cnt;
    logic [2*W-1:0] r_acc;
    logic [2*W-1:0] r_a;
    logic [W-1:0]   r_b;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run <= 1'b0;
        end else if (i_start) begin
            r_run <= 1'b1;
        end else if (r_run && r_cnt == '0) begin
            r_run <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_acc <= '0;
            r_a   <= (2*W)'(i_a);
            r_b   <= i_b;
            r_cnt <= CW'(W);
        end else if (r_run && r_cnt != '0) begin
            if (r_b[0]) begin
                r_acc <= r_acc + r_a;
            end
            r_a   <= r_a << 1;
            r_b   <= r_b >> 1;
            r_cnt <= r_cnt - CW'(1);
        end
    end

    assign o_p    = r_acc;
    assign o_done = r_run && (r_cnt == '0);

endmodule
`default_nettype wire

FILE: src/kcr_isqrt.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// kcr_isqrt
// truncating integer square root, one root bit per cycle
// ----------------------------------------------------------------------------
module kcr_isqrt #(
    parameter int W = 27
) (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_start,
    input  wire logic [2*W-1:0] i_v,
    output logic      [W-1:0]   o_root,
    output logic                o_done
);

    localparam int CW = $clog2(W + 1);

    logic           r_run;
    logic [CW-1:0]  r_cnt;
    logic [W-1:0]   r_rem;
    logic [W-1:0]   r_root;
    logic [2*W-1:0] r_v;
    logic [W+1:0]   rem2;
    logic [W+1:0]   trial;
    logic           ge;

    // partial remainder stays below 2^W until the last root bit
    assign rem2  = {r_rem, r_v[2*W-1 -: 2]};
    assign trial = {r_root, 2'b01};
    assign ge    = rem2 >= trial;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run <= 1'b0;
        end else if (i_start) begin
            r_run <= 1'b1;
        end else if (r_run && r_cnt == '0) begin
            r_run <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem  <= '0;
            r_root <= '0;
            r_v    <= i_v;
            r_cnt  <= CW'(W);
        end else if (r_run && r_cnt != '0) begin
            r_rem  <= W'(ge ? (rem2 - trial) : rem2);
            r_root <= {r_root[W-2:0], ge};
            r_v    <= r_v << 2;
            r_cnt  <= r_cnt - CW'(1);
        end
    end

    assign o_root = r_root;
    assign o_done = r_run && (r_cnt == '0);

endmodule
`default_nettype wire

FILE: src/kcr_div.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// kcr_div
// restoring divider, one quotient bit per cycle
// ----------------------------------------------------------------------------
module kcr_div #(
    parameter int NW = 42,
    parameter int DW = 27
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_start,
    input  wire logic [NW-1:0] i_n,
    input  wire logic [DW-1:0] i_d,
    output logic      [NW-1:0] o_q,
    output logic               o_done
);

    localparam int CW = $clog2(NW + 1);

    logic          r_run;
    logic [CW-1:0] r_cnt;
    logic [DW-1:0] r_rem;
    logic [DW-1:0] r_d;
    logic [NW-1:0] r_n;
    logic [NW-1:0] r_q;
    logic [DW:0]   r2;
    logic          ge;

    assign r2 = {r_rem, r_n[NW-1]};
    assign ge = r2 >= {1'b0, r_d};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run <= 1'b0;
        end else if (i_start) begin
            r_run <= 1'b1;
        end else if (r_run && r_cnt == '0) begin
            r_run <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= '0;
            r_q   <= '0;
            r_n   <= i_n;
            r_d   <= i_d;
            r_cnt <= CW'(NW);
        end else if (r_run && r_cnt != '0) begin
            r_rem <= ge ? DW'(r2 - {1'b0, r_d}) : r2[DW-1:0];
            r_q   <= {r_q[NW-2:0], ge};
            r_n   <= r_n << 1;
            r_cnt <= r_cnt - CW'(1);
        end
    end

    assign o_q    = r_q;
    assign o_done = r_run && (r_cnt == '0);

endmodule
`default_nettype wire

FILE: src/kcr_dp.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// kcr_dp
// rating store, similarity accumulation, arithmetic units, neighbor list
// ----------------------------------------------------------------------------
module kcr_dp #(
    parameter int MAX_USERS     = 256,
    parameter int MAX_ITEMS     = 1024,
    parameter int MAX_NEIGHBORS = 16
) (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    input  wire kcr_pkg::t_cmd                       i_cmd,
    output kcr_pkg::t_sts                            o_sts,
    input  wire logic [kcr_pkg::USER_W-1:0]          i_user,
    input  wire logic [kcr_pkg::ITEM_W-1:0]          i_item,
    input  wire logic [kcr_pkg::RATING_W-1:0]        i_rating,
    input  wire logic [kcr_pkg::CFG_USERS_W-1:0]     i_users_in_use,
    input  wire logic [kcr_pkg::CFG_ITEMS_W-1:0]     i_items_in_use,
    input  wire logic [kcr_pkg::CFG_NBRS_W-1:0]      i_neighbor_count,
    output logic      [kcr_pkg::PRED_W-1:0]          o_predicted,
    output logic                                     o_status
);

    localparam int RW     = kcr_pkg::RATING_W;
    localparam int SW     = kcr_pkg::SIM_W;
    localparam int DEPTH  = MAX_USERS * MAX_ITEMS;
    localparam int AW     = $clog2(DEPTH);
    localparam int BW     = AW + 1;
    localparam int UC_W   = $clog2(MAX_USERS + 1);
    localparam int IC_W   = $clog2(MAX_ITEMS + 1);
    localparam int KC_W   = $clog2(MAX_NEIGHBORS + 1);
    localparam int KIX_W  = (MAX_NEIGHBORS > 1) ? $clog2(MAX_NEIGHBORS) : 1;
    localparam int ACC_W  = 2 * RW + IC_W;
    localparam int NUM_W  = SW + RW + KC_W;
    localparam int DEN_W  = SW + KC_W;
    localparam int FN_W   = NUM_W + 2;
    localparam int FD_W   = DEN_W + 1;
    localparam int SN_W   = ACC_W + kcr_pkg::SIM_FRAC;
    localparam int DIV_NW = (SN_W > FN_W) ? SN_W : FN_W;
    localparam int DIV_DW = (ACC_W > FD_W) ? ACC_W : FD_W;

    typedef struct packed {
        logic [SW-1:0]   sim;
        logic [UC_W-1:0] who;
        logic [RW-1:0]   rat;
    } t_nbr;

    function automatic logic ranks_above(input t_nbr x, input t_nbr y);
        return (x.sim > y.sim) || ((x.sim == y.sim) && (x.who > y.who));
    endfunction

    // rating store
    logic [RW-1:0]   r_store [DEPTH];
    logic [RW-1:0]   r_rda;
    logic [RW-1:0]   r_rdb;
    logic [AW-1:0]   r_clr;
    logic            mem_we;
    logic [AW-1:0]   mem_wa;
    logic [RW-1:0]   mem_wd;
    logic [AW-1:0]   ld_addr;
    logic [BW-1:0]   row_base;
    logic            ld_ok;
    logic [AW-1:0]   rd_a;
    logic [AW-1:0]   rd_b;

    // prediction context
    logic [kcr_pkg::USER_W-1:0] r_user;
    logic [kcr_pkg::ITEM_W-1:0] r_item;
    logic [UC_W-1:0] r_nu;
    logic [IC_W-1:0] r_ni;
    logic [KC_W-1:0] r_k;
    logic [UC_W-1:0] r_u;
    logic [BW-1:0]   r_tgt_base;
    logic [BW-1:0]   r_cand_base;
    logic [RW-1:0]   r_crat;

    // accumulation pipeline
    logic [IC_W-1:0]   r_i;
    logic              r_iss;
    logic              r_v1;
    logic              r_v2;
    logic [2*RW-1:0]   r_pd;
    logic [2*RW-1:0]   r_pa;
    logic [2*RW-1:0]   r_pb;
    logic [ACC_W-1:0]  r_dot;
    logic [ACC_W-1:0]  r_ma;
    logic [ACC_W-1:0]  r_mb;
    logic              both;

    // arithmetic units
    logic [2*ACC_W-1:0] mul_p;
    logic               mul_done;
    logic [ACC_W-1:0]   root;
    logic               sqrt_done;
    logic [DIV_NW-1:0]  div_n;
    logic [DIV_DW-1:0]  div_d;
    logic [DIV_NW-1:0]  div_q;
    logic               div_done;
    logic [FN_W-1:0]    fin_n;
    logic [FD_W-1:0]    fin_d;
    logic [SW-1:0]      sim_q;

    // neighbor list and weighted sum
    t_nbr                     r_list [MAX_NEIGHBORS];
    t_nbr                     n_list [MAX_NEIGHBORS];
    logic [MAX_NEIGHBORS-1:0] gt;
    logic [KC_W-1:0]          r_cnt;
    logic [KC_W-1:0]          n_cnt;
    t_nbr                     nbr_new;
    t_nbr                     sel;
    logic [KC_W-1:0]          r_j;
    logic [NUM_W-1:0]         r_num;
    logic [DEN_W-1:0]         r_den;
    logic [kcr_pkg::PRED_W-1:0] r_pred;
    logic                     r_stat;

    assign row_base = BW'(i_user) * BW'(MAX_ITEMS);
    assign ld_addr  = AW'(row_base + BW'(i_item));
    assign ld_ok    = (int'(i_user) < MAX_USERS) && (int'(i_item) < MAX_ITEMS);

    assign mem_we = i_cmd.clr_step || (i_cmd.load_wr && ld_ok);
    assign mem_wa = i_cmd.clr_step ? r_clr : ld_addr;
    assign mem_wd = i_cmd.clr_step ? '0 : i_rating;

    assign rd_a = AW'(r_iss ? (r_cand_base + BW'(r_i)) : (r_cand_base + BW'(r_item)));
    assign rd_b = AW'(r_tgt_base + BW'(r_i));

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_store[mem_wa] <= mem_wd;
        end
        r_rda <= r_store[rd_a];
        r_rdb <= r_store[rd_b];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr <= '0;
        end else if (i_cmd.clr_step) begin
            r_clr <= r_clr + AW'(1);
        end
    end

    // context and candidate walk
    always_ff @(posedge i_clk) begin
        if (i_cmd.pred_init) begin
            r_user      <= i_user;
            r_item      <= i_item;
            r_nu        <= (int'(i_users_in_use) > MAX_USERS) ? UC_W'(MAX_USERS)
                                                               : UC_W'(i_users_in_use);
            r_ni        <= (int'(i_items_in_use) > MAX_ITEMS) ? IC_W'(MAX_ITEMS)
                                                               : IC_W'(i_items_in_use);
            r_k         <= (int'(i_neighbor_count) > MAX_NEIGHBORS) ? KC_W'(MAX_NEIGHBORS)
                                                                     : KC_W'(i_neighbor_count);
            r_u         <= '0;
            r_tgt_base  <= row_base;
            r_cand_base <= '0;
        end else if (i_cmd.next_cand) begin
            r_u         <= r_u + UC_W'(1);
            r_cand_base <= r_cand_base + BW'(MAX_ITEMS);
        end
        if (i_cmd.acc_start) begin
            r_crat <= r_rda;
        end
    end

    // item sweep: issue, read, multiply, accumulate
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_iss <= 1'b0;
            r_v1  <= 1'b0;
            r_v2  <= 1'b0;
        end else begin
            r_v1 <= r_iss;
            r_v2 <= r_v1;
            if (i_cmd.acc_start) begin
                r_iss <= 1'b1;
            end else if (r_iss && r_i == r_ni - IC_W'(1)) begin
                r_iss <= 1'b0;
            end
        end
    end

    assign both = (r_rda != '0) && (r_rdb != '0);

    always_ff @(posedge i_clk) begin
        if (i_cmd.acc_start) begin
            r_i <= '0;
        end else if (r_iss) begin
            r_i <= r_i + IC_W'(1);
        end
        r_pd <= both ? (2*RW)'(r_rda) * (2*RW)'(r_rdb) : '0;
        r_pa <= both ? (2*RW)'(r_rdb) * (2*RW)'(r_rdb) : '0;
        r_pb <= both ? (2*RW)'(r_rda) * (2*RW)'(r_rda) : '0;
        if (i_cmd.acc_start) begin
            r_dot <= '0;
            r_ma  <= '0;
            r_mb  <= '0;
        end else if (r_v2) begin
            r_dot <= r_dot + ACC_W'(r_pd);
            r_ma  <= r_ma + ACC_W'(r_pa);
            r_mb  <= r_mb + ACC_W'(r_pb);
        end
    end

    kcr_mul #(
        .W (ACC_W)
    ) u_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_cmd.mul_start),
        .i_a     (r_ma),
        .i_b     (r_mb),
        .o_p     (mul_p),
        .o_done  (mul_done)
    );

    kcr_isqrt #(
        .W (ACC_W)
    ) u_isqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_cmd.sqrt_start),
        .i_v     (mul_p),
        .o_root  (root),
        .o_done  (sqrt_done)
    );

    // one divider serves both the similarity and the final mean
    assign fin_n = FN_W'({r_num, 1'b0}) + FN_W'(r_den);
    assign fin_d = {r_den, 1'b0};
    assign div_n = i_cmd.div_sim_start ? DIV_NW'({r_dot, {kcr_pkg::SIM_FRAC{1'b0}}})
                                       : DIV_NW'(fin_n);
    assign div_d = i_cmd.div_sim_start ? DIV_DW'(root) : DIV_DW'(fin_d);

    kcr_div #(
        .NW (DIV_NW),
        .DW (DIV_DW)
    ) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_cmd.div_sim_start || i_cmd.div_fin_start),
        .i_n     (div_n),
        .i_d     (div_d),
        .o_q     (div_q),
        .o_done  (div_done)
    );

    assign sim_q = (div_q > DIV_NW'(kcr_pkg::SIM_ONE)) ? kcr_pkg::SIM_ONE : div_q[SW-1:0];

    // sorted insertion, every slot decided in parallel
    always_comb begin
        nbr_new.sim = i_cmd.ins_zero ? '0 : sim_q;
        nbr_new.who = r_u;
        nbr_new.rat = r_crat;
        for (int p = 0; p < MAX_NEIGHBORS; p++) begin
            gt[p] = (p < int'(r_cnt)) && ranks_above(nbr_new, r_list[p]);
        end
        n_list = r_list;
        if (r_k != '0 && (gt[0] || r_cnt == '0)) begin
            n_list[0] = nbr_new;
        end
        for (int p = 1; p < MAX_NEIGHBORS; p++) begin
            if (p < int'(r_k)) begin
                if (gt[p-1]) begin
                    n_list[p] = r_list[p-1];
                end else if (gt[p] || p == int'(r_cnt)) begin
                    n_list[p] = nbr_new;
                end
            end
        end
        n_cnt = (r_cnt < r_k) ? r_cnt + KC_W'(1) : r_cnt;
    end

    assign sel = r_list[r_j[KIX_W-1:0]];

    always_ff @(posedge i_clk) begin
        if (i_cmd.pred_init) begin
            r_cnt <= '0;
            r_j   <= '0;
            r_num <= '0;
            r_den <= '0;
        end else if (i_cmd.ins_zero || i_cmd.ins_div) begin
            r_list <= n_list;
            r_cnt  <= n_cnt;
        end else if (i_cmd.sum_step) begin
            r_num <= r_num + NUM_W'(sel.sim) * NUM_W'(sel.rat);
            r_den <= r_den + DEN_W'(sel.sim);
            r_j   <= r_j + KC_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_err) begin
            r_pred <= '0;
            r_stat <= kcr_pkg::STAT_RANGE;
        end else if (i_cmd.fin_zero) begin
            r_pred <= '0;
            r_stat <= kcr_pkg::STAT_OK;
        end else if (i_cmd.fin_q) begin
            r_pred <= div_q[kcr_pkg::PRED_W-1:0];
            r_stat <= kcr_pkg::STAT_OK;
        end
    end

    assign o_predicted = r_pred;
    assign o_status    = r_stat;

    assign o_sts.clr_last  = (r_clr == AW'(DEPTH - 1));
    assign o_sts.pred_bad  = (int'(r_user) >= int'(r_nu)) || (int'(r_item) >= int'(r_ni));
    assign o_sts.cand_skip = (int'(r_u) == int'(r_user)) || (r_rda == '0);
    assign o_sts.acc_done  = !r_iss && !r_v1 && !r_v2;
    assign o_sts.mag_zero  = (r_ma == '0) || (r_mb == '0);
    assign o_sts.mul_done  = mul_done;
    assign o_sts.sqrt_done = sqrt_done;
    assign o_sts.div_done  = div_done;
    assign o_sts.last_cand = (r_u + UC_W'(1)) == r_nu;
    assign o_sts.sum_more  = r_j < r_cnt;
    assign o_sts.den_zero  = (r_den == '0);

endmodule
`default_nettype wire

FILE: src/kcr_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// kcr_ctrl
// controller: clearing pass, load, candidate walk, arithmetic sequencing
// ----------------------------------------------------------------------------
module kcr_ctrl (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_start,
    input  wire logic          i_func,
    input  wire kcr_pkg::t_sts i_sts,
    output kcr_pkg::t_cmd      o_cmd,
    output logic               o_busy,
    output logic               o_valid
);

    typedef enum logic [13:0] {
        S_CLEAR = 14'b00000000000001,
        S_IDLE  = 14'b00000000000010,
        S_CHECK = 14'b00000000000100,
        S_CRD   = 14'b00000000001000,
        S_CCHK  = 14'b00000000010000,
        S_ACC   = 14'b00000000100000,
        S_MUL   = 14'b00000001000000,
        S_SQRT  = 14'b00000010000000,
        S_DIV   = 14'b00000100000000,
        S_NEXT  = 14'b00001000000000,
        S_SUM   = 14'b00010000000000,
        S_FDIV  = 14'b00100000000000,
        S_OUT   = 14'b01000000000000,
        S_SPARE = 14'b10000000000000
    } t_state;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        o_busy  = 1'b1;
        o_valid = 1'b0;
        case (r_state)
            S_CLEAR: begin
                o_cmd.clr_step = 1'b1;
                if (i_sts.clr_last) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                o_busy = 1'b0;
                if (i_start) begin
                    if (i_func == kcr_pkg::FUNC_PREDICT) begin
                        o_cmd.pred_init = 1'b1;
                        n_state = S_CHECK;
                    end else begin
                        o_cmd.load_wr = 1'b1;
                    end
                end
            end
            S_CHECK: begin
                if (i_sts.pred_bad) begin
                    o_cmd.out_err = 1'b1;
                    n_state = S_OUT;
                end else begin
                    n_state = S_CRD;
                end
            end
            S_CRD: begin
                n_state = S_CCHK;
            end
            S_CCHK: begin
                if (i_sts.cand_skip) begin
                    n_state = S_NEXT;
                end else begin
                    o_cmd.acc_start = 1'b1;
                    n_state = S_ACC;
                end
            end
            S_ACC: begin
                if (i_sts.acc_done) begin
                    if (i_sts.mag_zero) begin
                        o_cmd.ins_zero = 1'b1;
                        n_state = S_NEXT;
                    end else begin
                        o_cmd.mul_start = 1'b1;
                        n_state = S_MUL;
                    end
                end
            end
            S_MUL: begin
                if (i_sts.mul_done) begin
                    o_cmd.sqrt_start = 1'b1;
                    n_state = S_SQRT;
                end
            end
            S_SQRT: begin
                if (i_sts.sqrt_done) begin
                    o_cmd.div_sim_start = 1'b1;
                    n_state = S_DIV;
                end
            end
            S_DIV: begin
                if (i_sts.div_done) begin
                    o_cmd.ins_div = 1'b1;
                    n_state = S_NEXT;
                end
            end
            S_NEXT: begin
                o_cmd.next_cand = 1'b1;
                n_state = i_sts.last_cand ? S_SUM : S_CRD;
            end
            S_SUM: begin
                if (i_sts.sum_more) begin
                    o_cmd.sum_step = 1'b1;
                end else if (i_sts.den_zero) begin
                    o_cmd.fin_zero = 1'b1;
                    n_state = S_OUT;
                end else begin
                    o_cmd.div_fin_start = 1'b1;
                    n_state = S_FDIV;
                end
            end
            S_FDIV: begin
                if (i_sts.div_done) begin
                    o_cmd.fin_q = 1'b1;
                    n_state = S_OUT;
                end
            end
            S_OUT: begin
                o_valid = 1'b1;
                n_state = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule
`default_nettype wire

FILE: src/knn_cosine_rating_predictor.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// knn_cosine_rating_predictor
// user-based cosine k-nearest-neighbor rating predictor over a rating store
// ----------------------------------------------------------------------------
// after reset the block sweeps the rating store to zero, one entry per cycle,
// all MAX_USERS*MAX_ITEMS entries, with busy high; configuration writes are
// taken meanwhile. a load transaction (func 0) is taken while idle and busy
// stays low. a predict transaction (func 1) raises busy until its result
// appears: an out-of-range request goes from the check state to the output
// state; otherwise every user row in use is visited, a skipped row (self,
// or no rating of the target item) passing only the read, check and next
// states, and a scored row being swept over its ni items in use, then, if
// it has a co-rated item, run through the bit-serial multiply and square
// root of width ACC_W = 16 + clog2(MAX_ITEMS+1) and the shared bit-serial
// divider of width DIV_NW (about ACC_W+15); the item sweep reads the target
// and candidate rows through the two store read ports, one item per cycle.
// finishing steps through the weighted sum over the kept neighbors, the
// divide (skipped when the weights sum to zero) and the output state. the
// result is shown for exactly one cycle on o_valid and must be taken then.
module knn_cosine_rating_predictor #(
    parameter int MAX_USERS     = 256,
    parameter int MAX_ITEMS     = 1024,
    parameter int MAX_NEIGHBORS = 16
) (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    // command transaction
    input  wire logic                              start,
    output logic                                   busy,
    input  wire logic                              i_func,
    input  wire logic [kcr_pkg::USER_W-1:0]        i_user,
    input  wire logic [kcr_pkg::ITEM_W-1:0]        i_item,
    input  wire logic [kcr_pkg::RATING_W-1:0]      i_rating,
    // configuration write port
    input  wire logic                              i_cfg_we,
    input  wire logic [kcr_pkg::CFG_IDX_W-1:0]     i_cfg_idx,
    input  wire logic [kcr_pkg::CFG_DATA_W-1:0]    i_cfg_data,
    // result strobe
    output logic                                   o_valid,
    output logic      [kcr_pkg::PRED_W-1:0]        o_predicted,
    output logic                                   o_status
);

    // configuration registers
    logic [kcr_pkg::CFG_USERS_W-1:0] r_users;
    logic [kcr_pkg::CFG_ITEMS_W-1:0] r_items;
    logic [kcr_pkg::CFG_NBRS_W-1:0]  r_nbrs;

    kcr_pkg::t_cmd cmd;
    kcr_pkg::t_sts sts;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_users <= kcr_pkg::USERS_RST;
            r_items <= kcr_pkg::ITEMS_RST;
            r_nbrs  <= kcr_pkg::NBRS_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                kcr_pkg::CFG_USERS: r_users <= i_cfg_data[kcr_pkg::CFG_USERS_W-1:0];
                kcr_pkg::CFG_ITEMS: r_items <= i_cfg_data[kcr_pkg::CFG_ITEMS_W-1:0];
                kcr_pkg::CFG_NBRS:  r_nbrs  <= i_cfg_data[kcr_pkg::CFG_NBRS_W-1:0];
                default: begin
                    // unused index, write dropped
                end
            endcase
        end
    end

    // sequencing: clear pass, load, candidate walk, arithmetic steps
    kcr_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start),
        .i_func  (i_func),
        .i_sts   (sts),
        .o_cmd   (cmd),
        .o_busy  (busy),
        .o_valid (o_valid)
    );

    // store, similarity math, neighbor list, result registers
    kcr_dp #(
        .MAX_USERS     (MAX_USERS),
        .MAX_ITEMS     (MAX_ITEMS),
        .MAX_NEIGHBORS (MAX_NEIGHBORS)
    ) u_dp (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cmd            (cmd),
        .o_sts            (sts),
        .i_user           (i_user),
        .i_item           (i_item),
        .i_rating         (i_rating),
        .i_users_in_use   (r_users),
        .i_items_in_use   (r_items),
        .i_neighbor_count (r_nbrs),
        .o_predicted      (o_predicted),
        .o_status         (o_status)
    );

    // result strobe lasts a single cycle
    a_valid_pulse: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |=> !o_valid)
        else $error("result strobe held longer than one cycle");

    // a predict transaction always leaves the block busy
    a_predict_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && i_func == kcr_pkg::FUNC_PREDICT) |=> busy)
        else $error("predict transaction did not raise busy");

    // a result only follows a busy cycle
    a_valid_after_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $past(busy))
        else $error("result without preceding work");

    // range errors report a zero prediction
    a_err_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_status == kcr_pkg::STAT_RANGE) |-> (o_predicted == '0))
        else $error("range error with nonzero prediction");

endmodule
`default_nettype wire

FILE: bench/kcr_rating_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kcr_rating_checker
// watches the command, configuration and result ports of the rating
// predictor, keeps its own copy of the rating store and settings, works out
// each expected prediction and compares it with the result strobe
// ----------------------------------------------------------------------------
module kcr_rating_checker (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              start,
    input  wire logic                              busy,
    input  wire logic                              i_func,
    input  wire logic [kcr_pkg::USER_W-1:0]        i_user,
    input  wire logic [kcr_pkg::ITEM_W-1:0]        i_item,
    input  wire logic [kcr_pkg::RATING_W-1:0]      i_rating,
    input  wire logic                              i_cfg_we,
    input  wire logic [kcr_pkg::CFG_IDX_W-1:0]     i_cfg_idx,
    input  wire logic [kcr_pkg::CFG_DATA_W-1:0]    i_cfg_data,
    input  wire logic                              o_valid,
    input  wire logic [kcr_pkg::PRED_W-1:0]        o_predicted,
    input  wire logic                              o_status,
    output int                                     o_fail_count,
    output int                                     o_pending
);

    localparam int N_USERS = 256;
    localparam int N_ITEMS = 1024;
    localparam int N_NBRS  = 16;

    typedef struct {
        logic [kcr_pkg::PRED_W-1:0] predicted;
        logic                       status;
    } t_answer;

    bit   [kcr_pkg::RATING_W-1:0]    store [0:N_USERS-1][0:N_ITEMS-1];
    logic [kcr_pkg::CFG_USERS_W-1:0] users_cfg;
    logic [kcr_pkg::CFG_ITEMS_W-1:0] items_cfg;
    logic [kcr_pkg::CFG_NBRS_W-1:0]  nbrs_cfg;
    t_answer                         answers_due [$];
    int                              fails;

    assign o_fail_count = fails;
    assign o_pending    = answers_due.size();

    function automatic longint unsigned int_sqrt(longint unsigned v);
        longint unsigned root;
        longint unsigned trial;
        root = 0;
        for (int b = 31; b >= 0; b--) begin
            trial = root | (64'd1 << b);
            if (trial * trial <= v)
                root = trial;
        end
        return root;
    endfunction

    // cosine of two user rows over co-rated items, unsigned q1.15
    function automatic int unsigned cosine_q15(int ua, int ub, int ni);
        longint unsigned dot, ma, mb, root, q;
        longint unsigned a, b;
        dot = 0; ma = 0; mb = 0;
        for (int i = 0; i < ni; i++) begin
            a = store[ua][i];
            b = store[ub][i];
            if (a != 0 && b != 0) begin
                dot += a * b;
                ma  += a * a;
                mb  += b * b;
            end
        end
        if (ma == 0 || mb == 0)
            return 0;
        root = int_sqrt(ma * mb);
        if (root == 0)
            return 0;
        q = (dot << kcr_pkg::SIM_FRAC) / root;
        return (q > 32768) ? 32768 : int'(q);
    endfunction

    function automatic bit outranks(int unsigned s1, int w1, int unsigned s2, int w2);
        return (s1 > s2) || (s1 == s2 && w1 > w2);
    endfunction

    function automatic t_answer predict_rating(int target, int item);
        t_answer         ans;
        int              nu, ni, k, cnt, pos;
        int unsigned     s;
        int unsigned     top_sim  [N_NBRS];
        int              top_user [N_NBRS];
        longint unsigned num, den, q;
        nu = (users_cfg > N_USERS) ? N_USERS : int'(users_cfg);
        ni = (items_cfg > N_ITEMS) ? N_ITEMS : int'(items_cfg);
        k  = (nbrs_cfg > N_NBRS) ? N_NBRS : int'(nbrs_cfg);
        if (target >= nu || item >= ni) begin
            ans.predicted = '0;
            ans.status    = kcr_pkg::STAT_RANGE;
            return ans;
        end
        cnt = 0;
        for (int u = 0; u < nu; u++) begin
            if (u == target || store[u][item] == 0)
                continue;
            s = cosine_q15(target, u, ni);
            if (cnt < k) begin
                pos = cnt;
                cnt++;
            end else if (k == 0 || !outranks(s, u, top_sim[k-1], top_user[k-1])) begin
                continue;
            end else begin
                pos = k - 1;
            end
            while (pos > 0 && outranks(s, u, top_sim[pos-1], top_user[pos-1])) begin
                top_sim[pos]  = top_sim[pos-1];
                top_user[pos] = top_user[pos-1];
                pos--;
            end
            top_sim[pos]  = s;
            top_user[pos] = u;
        end
        num = 0; den = 0;
        for (int j = 0; j < cnt; j++) begin
            num += longint'(top_sim[j]) * store[top_user[j]][item];
            den += top_sim[j];
        end
        q = (den == 0) ? 0 : (2 * num + den) / (2 * den);
        ans.predicted = q[kcr_pkg::PRED_W-1:0];
        ans.status    = kcr_pkg::STAT_OK;
        return ans;
    endfunction

    always @(posedge i_clk) begin
        t_answer want;
        t_answer due;
        if (!i_rst_n) begin
            foreach (store[u, i])
                store[u][i] = '0;
            users_cfg <= kcr_pkg::USERS_RST;
            items_cfg <= kcr_pkg::ITEMS_RST;
            nbrs_cfg  <= kcr_pkg::NBRS_RST;
            fails     = 0;
            answers_due.delete();
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    kcr_pkg::CFG_USERS: users_cfg <= i_cfg_data[kcr_pkg::CFG_USERS_W-1:0];
                    kcr_pkg::CFG_ITEMS: items_cfg <= i_cfg_data[kcr_pkg::CFG_ITEMS_W-1:0];
                    kcr_pkg::CFG_NBRS:  nbrs_cfg  <= i_cfg_data[kcr_pkg::CFG_NBRS_W-1:0];
                    default: ;
                endcase
            end
            if (start && !busy) begin
                if (i_func == kcr_pkg::FUNC_LOAD) begin
                    store[i_user][i_item] = i_rating;
                end else begin
                    due = predict_rating(int'(i_user), int'(i_item));
                    answers_due.insert(answers_due.size(), due);
                end
            end
            if (o_valid) begin
                if (answers_due.size() == 0) begin
                    fails++;
                    if (fails <= 10)
                        $display("unexpected result: predicted %0d status %0d",
                                 o_predicted, o_status);
                end else begin
                    want = answers_due.pop_front();
                    if (o_predicted !== want.predicted || o_status !== want.status) begin
                        fails++;
                        if (fails <= 10)
                            $display("mismatch: expected predicted %0d status %0d, got %0d %0d",
                                     want.predicted, want.status, o_predicted, o_status);
                    end
                end
            end
        end
    end

endmodule

FILE: bench/tb_knn_cosine_rating_predictor.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_knn_cosine_rating_predictor
// drives load and predict transactions with random gaps through several
// store sizes and neighbor counts, the checker beside the block predicts and
// compares every result, and this module gives the verdict
// ----------------------------------------------------------------------------
module tb_knn_cosine_rating_predictor;

    // the clearing pass alone sweeps all 256*1024 store entries, and each
    // full-size prediction sweeps all 1024 items of every scored row; this
    // leaves several times the slowest run
    localparam int CYCLE_LIMIT = 10000000;

    logic                              i_clk      = 1'b0;
    logic                              i_rst_n    = 1'b0;
    logic                              start      = 1'b0;
    logic                              i_func     = kcr_pkg::FUNC_LOAD;
    logic [kcr_pkg::USER_W-1:0]        i_user     = '0;
    logic [kcr_pkg::ITEM_W-1:0]        i_item     = '0;
    logic [kcr_pkg::RATING_W-1:0]      i_rating   = '0;
    logic                              i_cfg_we   = 1'b0;
    logic [kcr_pkg::CFG_IDX_W-1:0]     i_cfg_idx  = kcr_pkg::CFG_USERS;
    logic [kcr_pkg::CFG_DATA_W-1:0]    i_cfg_data = '0;
    logic                              busy;
    logic                              o_valid;
    logic [kcr_pkg::PRED_W-1:0]        o_predicted;
    logic                              o_status;
    int                                fail_count;
    int                                pending;
    int                                cycles     = 0;
    bit                                no_gaps    = 1'b0;

    always #6 i_clk = ~i_clk;

    knn_cosine_rating_predictor DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .start       (start),
        .busy        (busy),
        .i_func      (i_func),
        .i_user      (i_user),
        .i_item      (i_item),
        .i_rating    (i_rating),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_data  (i_cfg_data),
        .o_valid     (o_valid),
        .o_predicted (o_predicted),
        .o_status    (o_status)
    );

    kcr_rating_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .start        (start),
        .busy         (busy),
        .i_func       (i_func),
        .i_user       (i_user),
        .i_item       (i_item),
        .i_rating     (i_rating),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_idx    (i_cfg_idx),
        .i_cfg_data   (i_cfg_data),
        .o_valid      (o_valid),
        .o_predicted  (o_predicted),
        .o_status     (o_status),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    // watchdog
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("Verification failed");
            $finish;
        end
    end

    // mostly short gaps, now and then a long one
    function automatic int pick_gap();
        int r;
        if (no_gaps)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(20, 60);
    endfunction

    // one command transaction; returns right after the accepting edge
    task automatic send(logic func, int user, int item, int rating);
        int  gap;
        bit  taken;
        gap = pick_gap();
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        start    <= 1'b1;
        i_func   <= func;
        i_user   <= user[kcr_pkg::USER_W-1:0];
        i_item   <= item[kcr_pkg::ITEM_W-1:0];
        i_rating <= rating[kcr_pkg::RATING_W-1:0];
        do begin
            @(negedge i_clk);
            taken = !busy;
            @(posedge i_clk);
        end while (!taken);
    endtask

    task automatic load(int user, int item, int rating);
        send(kcr_pkg::FUNC_LOAD, user, item, rating);
    endtask

    task automatic predict(int user, int item);
        send(kcr_pkg::FUNC_PREDICT, user, item, 0);
    endtask

    // wait until the block is idle and every answer is back
    task automatic settle();
        start <= 1'b0;
        @(posedge i_clk);
        while (pending != 0 || busy)
            @(posedge i_clk);
        repeat (8) @(posedge i_clk);
    endtask

    task automatic write_cfg(logic [kcr_pkg::CFG_IDX_W-1:0] idx, int value);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= value[kcr_pkg::CFG_DATA_W-1:0];
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic set_sizes(int users, int items, int nbrs);
        settle();
        write_cfg(kcr_pkg::CFG_USERS, users);
        write_cfg(kcr_pkg::CFG_ITEMS, items);
        write_cfg(kcr_pkg::CFG_NBRS, nbrs);
    endtask

    task automatic random_phase(int users, int items, int nbrs, int count);
        int r, u_lim, i_lim, rt;
        set_sizes(users, items, nbrs);
        u_lim = (users > 256) ? 255 : users + 1;
        i_lim = (items >= 1024) ? 1023 : items;
        if (u_lim > 255) u_lim = 255;
        for (int n = 0; n < count; n++) begin
            r  = $urandom_range(0, 99);
            rt = ($urandom_range(0, 4) == 0) ? 0 : $urandom_range(1, 255);
            if (r < 55)
                load($urandom_range(0, u_lim), $urandom_range(0, i_lim), rt);
            else if (r < 88)
                predict($urandom_range(0, u_lim), $urandom_range(0, i_lim));
            else if (r < 94)
                load($urandom_range(0, 255), $urandom_range(0, 1023), rt);
            else
                predict($urandom_range(0, 255), $urandom_range(0, 1023));
        end
    endtask

    initial begin
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: small store, two neighbors
        write_cfg(kcr_pkg::CFG_USERS, 4);
        write_cfg(kcr_pkg::CFG_ITEMS, 8);
        write_cfg(kcr_pkg::CFG_NBRS, 2);
        load(0, 0, 8'h10); load(0, 1, 8'h20); load(0, 2, 8'hFF);
        load(1, 0, 8'h30); load(1, 1, 8'h01);
        // nearly the same direction as user 0, similarity just under one
        load(2, 1, 8'h40); load(2, 2, 8'hFF); load(2, 0, 8'h20);
        // tie with user 1
        load(3, 0, 8'h30); load(3, 1, 8'h01);
        predict(0, 0);
        predict(1, 2);
        predict(0, 7);                    // nobody else rated the item
        predict(4, 0);                    // user out of range
        predict(0, 8);                    // item out of range
        load(5, 0, 8'hA0);                // beyond the users in use, still stored
        load(3, 3, 8'h00);
        // user 1 is the only candidate for item 7 and shares co-rated items with the target
        load(1, 7, 8'h55);
        load(2, 5, 8'h77);
        predict(2, 7);

        set_sizes(4, 8, 0);               // no neighbors kept
        predict(0, 0);
        set_sizes(0, 8, 5);               // every prediction fails
        predict(0, 0);
        set_sizes(511, 2047, 31);         // oversized settings clamp to maxima
        load(255, 1023, 8'hFF);
        load(200, 0, 8'h80);
        predict(0, 0);
        predict(255, 1023);
        set_sizes(1, 1, 16);              // only the target user itself
        predict(0, 0);
        set_sizes(256, 1024, 16);
        predict(5, 0);

        // random: mostly dense small stores so neighbors overlap
        no_gaps = 1'b1;
        random_phase(6, 12, 3, 20);
        no_gaps = 1'b0;
        random_phase($urandom_range(2, 12), $urandom_range(1, 24), $urandom_range(0, 16), 25);
        random_phase($urandom_range(2, 12), $urandom_range(1, 24), $urandom_range(17, 31), 20);
        random_phase(12, 24, 16, 20);
        random_phase(256, 1024, 1, 15);

        settle();
        repeat (50) @(posedge i_clk);
        if (fail_count == 0 && pending == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule

FILE: filelist.f
src/kcr_pkg.sv
src/kcr_mul.sv
src/kcr_isqrt.sv
src/kcr_div.sv
src/kcr_dp.sv
src/kcr_ctrl.sv
src/knn_cosine_rating_predictor.sv
bench/kcr_rating_checker.sv
bench/tb_knn_cosine_rating_predictor.sv
